// ----- sv/hcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared types, command codes, symbol slots and the character mapping.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int ALPHABET_SIZE_DEF = 30;
  localparam int MAX_CODE_LEN      = 32;
  localparam int WORD_LIMIT        = 32;
  localparam int LEN_LIMIT         = (MAX_CODE_LEN < WORD_LIMIT) ? MAX_CODE_LEN : WORD_LIMIT;
  localparam int ACC_W             = 40;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;

  localparam logic [4:0] SLOT_SPACE   = 5'd26;
  localparam logic [4:0] SLOT_PERIOD  = 5'd27;
  localparam logic [4:0] SLOT_NEWLINE = 5'd28;
  localparam logic [4:0] SLOT_END     = 5'd29;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PERIOD  = 8'h2e;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_MERGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  symbol_char;
    logic [4:0]  entry_index;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] slot;
  } char_map_t;

  function automatic char_map_t map_char(input logic [7:0] ch);
    char_map_t m;
    m.hit  = 1'b1;
    m.slot = '0;
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      m.slot = 5'(ch - CHAR_LOWER_A);
    end else if (ch == CHAR_SPACE) begin
      m.slot = SLOT_SPACE;
    end else if (ch == CHAR_PERIOD) begin
      m.slot = SLOT_PERIOD;
    end else if (ch == CHAR_NEWLINE) begin
      m.slot = SLOT_NEWLINE;
    end else begin
      m.hit = 1'b0;
    end
    return m;
  endfunction

endpackage

// ----- sv/huffman_code_bit_packer.sv -----
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Table-driven Huffman encoder that packs codes MSB first into output bytes.
// ----------------------------------------------------------------------------
// A load word writes the code table. An encode or end word reads its code,
// then passes through the align, merge and emit states; an end word also
// flushes any remaining bits as a padded last byte. Input stalls outside idle.
// The one shared 40-bit shifter aligns the code and merges it with the pending
// bits; emit then releases one byte per cycle while the output is not stalled.
// Reset clears the code table valid bits, the pending bits and all control.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
  parameter int ALPHABET_SIZE = hcbp_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcbp_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output hcbp_pkg::out_word_t out_word
);
  import hcbp_pkg::*;

  localparam int AW = $clog2(ALPHABET_SIZE);

  state_t state_r, state_nxt;

  logic [37:0]        mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid_r;
  logic [37:0]        rd_q_r;
  logic               rd_hit_r;

  logic               is_end_r, is_end_nxt;
  logic               emitted_r, emitted_nxt;
  logic [5:0]         len_r, len_nxt;
  logic [ACC_W-1:0]   sr_r, sr_nxt;
  logic [5:0]         cnt_r, cnt_nxt;
  logic [7:0]         pend_r, pend_nxt;
  logic [2:0]         pcnt_r, pcnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               in_acc;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [5:0]         len_sat;
  logic [5:0]         len_eff;
  char_map_t          cmap;
  logic               go_busy;
  logic               can_emit;
  logic               emit_full;
  logic               end_done;

  logic               sh_left;
  logic [ACC_W-1:0]   sh_in;
  logic [5:0]         sh_amt;
  logic [ACC_W-1:0]   sh_out;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cmap      = map_char(in_word.symbol_char);
  assign wr_en     = in_acc && (in_word.cmd == CMD_LOAD)
                     && (int'(in_word.entry_index) < ALPHABET_SIZE);
  assign wr_addr   = AW'(in_word.entry_index);
  assign rd_addr   = (in_word.cmd == CMD_END) ? AW'(SLOT_END) : AW'(cmap.slot);
  assign len_sat   = (in_word.code_length > 6'(LEN_LIMIT)) ? 6'(LEN_LIMIT)
                                                           : in_word.code_length;
  assign go_busy   = in_acc && ((in_word.cmd == CMD_END)
                     || ((in_word.cmd == CMD_ENCODE) && cmap.hit));
  assign len_eff   = rd_hit_r ? rd_q_r[37:32] : 6'd0;
  assign can_emit  = !out_valid_r || !out_stall;
  assign emit_full = (cnt_r >= 6'd8);
  assign end_done  = is_end_r && (cnt_r == 6'd0) && emitted_r;

  assign sh_out = sh_left ? (sh_in << sh_amt) : (sh_in >> sh_amt);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {len_sat, in_word.code_bits};
    end
    if (in_acc) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (in_acc) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (go_busy) state_nxt = ST_ALIGN;
      ST_ALIGN: state_nxt = ST_MERGE;
      ST_MERGE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_full) begin
          state_nxt = ST_EMIT;
        end else if (is_end_r && !end_done && !can_emit) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    is_end_nxt    = is_end_r;
    emitted_nxt   = emitted_r;
    len_nxt       = len_r;
    sr_nxt        = sr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pcnt_nxt      = pcnt_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    sh_left       = 1'b1;
    sh_in         = sr_r;
    sh_amt        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          is_end_nxt  = (in_word.cmd == CMD_END);
          emitted_nxt = 1'b0;
        end
      end
      ST_ALIGN: begin
        sh_left = 1'b1;
        sh_in   = {8'd0, rd_q_r[31:0]};
        sh_amt  = 6'(ACC_W) - len_eff;
        sr_nxt  = sh_out;
        len_nxt = len_eff;
      end
      ST_MERGE: begin
        sh_left = 1'b0;
        sh_in   = sr_r;
        sh_amt  = {3'd0, pcnt_r};
        sr_nxt  = {pend_r, 32'd0} | sh_out;
        cnt_nxt = {3'd0, pcnt_r} + len_r;
      end
      ST_EMIT: begin
        if (emit_full) begin
          if (can_emit) begin
            out_valid_nxt         = 1'b1;
            out_word_nxt.out_byte = sr_r[ACC_W-1 -: 8];
            out_word_nxt.last     = is_end_r && (cnt_r == 6'd8);
            sr_nxt                = sr_r << 8;
            cnt_nxt               = cnt_r - 6'd8;
            emitted_nxt           = 1'b1;
          end
        end else if (is_end_r) begin
          if (end_done) begin
            pend_nxt = '0;
            pcnt_nxt = '0;
          end else if (can_emit) begin
            out_valid_nxt         = 1'b1;
            out_word_nxt.out_byte = sr_r[ACC_W-1 -: 8];
            out_word_nxt.last     = 1'b1;
            pend_nxt              = '0;
            pcnt_nxt              = '0;
          end
        end else begin
          pend_nxt = sr_r[ACC_W-1 -: 8];
          pcnt_nxt = cnt_r[2:0];
        end
      end
      default: begin
        sh_amt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      is_end_r    <= 1'b0;
      emitted_r   <= 1'b0;
      cnt_r       <= '0;
      pend_r      <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      is_end_r    <= is_end_nxt;
      emitted_r   <= emitted_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      pcnt_r      <= pcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    sr_r       <= sr_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
